>>> rtl/gcfr_pkg.sv
// Shared types, constants and fixed-point helpers of the GRU cell with readout.
// Used by the MAC, divider and top-level modules; depends on nothing else.
package gcfr_pkg;

  localparam int ACC_W = 48;
  localparam logic signed [15:0] Q_ONE = 16'sd4096;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_STEP  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctl_t;

  function automatic logic signed [15:0] round_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] b;
    logic signed [ACC_W-1:0] s;
    b = acc + ACC_W'(2048);
    s = b >>> 12;
    if (s > ACC_W'(32767)) begin
      round_sat = 16'sh7fff;
    end else if (s < -ACC_W'(32768)) begin
      round_sat = -16'sh8000;
    end else begin
      round_sat = s[15:0];
    end
  endfunction

  function automatic logic signed [15:0] sigm(input logic signed [16:0] x);
    logic [17:0] a;
    logic [12:0] y;
    a = x[16] ? 18'(-{x[16], x}) : 18'({x[16], x});
    if (a >= 18'd20480) begin
      y = 13'd4096;
    end else if (a >= 18'd9728) begin
      y = 13'(a >> 5) + 13'd3456;
    end else if (a >= 18'd4096) begin
      y = 13'(a >> 3) + 13'd2560;
    end else begin
      y = 13'(a >> 2) + 13'd2048;
    end
    sigm = x[16] ? (Q_ONE - 16'(y)) : 16'(y);
  endfunction

  function automatic logic signed [15:0] tanh_q(input logic signed [15:0] x);
    logic signed [15:0] s;
    s = sigm(signed'({x, 1'b0}));
    tanh_q = signed'({s[14:0], 1'b0}) - Q_ONE;
  endfunction

endpackage

>>> rtl/gcfr_wmem.sv
// Weight and bias store: one write port, one registered read port.
// Stand-alone; no package dependency.
module gcfr_wmem #(
  parameter int DEPTH = 4096,
  parameter int AW = 12
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  logic signed [15:0]  wdata,
  input  logic [AW-1:0]       raddr,
  output logic signed [15:0]  rdata
);

  logic signed [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/gcfr_smem.sv
// State memory: hidden banks, gate and scratch vectors; one write, two reads.
// Stand-alone; no package dependency.
module gcfr_smem #(
  parameter int DEPTH = 128,
  parameter int AW = 7
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  logic signed [15:0]  wdata,
  input  logic [AW-1:0]       raddr_a,
  input  logic [AW-1:0]       raddr_b,
  output logic signed [15:0]  rdata_a,
  output logic signed [15:0]  rdata_b
);

  logic signed [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

>>> rtl/gcfr_mac.sv
// Two-stage multiply-accumulate: registered product, then accumulation.
// Depends on gcfr_pkg for the accumulator width and control struct.
module gcfr_mac (
  input  logic                              clk,
  input  logic                              rst,
  input  gcfr_pkg::mac_ctl_t                ctl,
  input  logic signed [15:0]                a,
  input  logic signed [15:0]                b,
  output logic                              done,
  output logic signed [gcfr_pkg::ACC_W-1:0] acc
);

  gcfr_pkg::mac_ctl_t pctl;
  logic signed [31:0] prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      pctl <= '0;
      done <= 1'b0;
    end else begin
      pctl <= ctl;
      done <= pctl.valid & pctl.last;
    end
    prod <= a * b;
    if (pctl.valid) begin
      acc <= (pctl.first ? '0 : acc) + gcfr_pkg::ACC_W'(prod);
    end
  end

endmodule

>>> rtl/gcfr_div.sv
// Restoring divider for softsign: q = (mag*2^15 + d/2) / d with d = 2^24 + mag.
// One quotient bit per cycle for a 16-bit quotient; depends on gcfr_pkg.
module gcfr_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [gcfr_pkg::ACC_W-1:0]        mag,
  output logic                              done,
  output logic [15:0]                       q
);

  localparam int NW = gcfr_pkg::ACC_W + 16;

  logic [NW-1:0] rem;
  logic [NW-1:0] dsh;
  logic [NW-1:0] d;
  logic [3:0]    cnt;
  logic          busy;
  logic          ge;

  assign d  = NW'(mag) + (NW'(1) << 24);
  assign ge = rem >= dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 4'd0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
    if (start) begin
      rem <= (NW'(mag) << 15) + (d >> 1);
      dsh <= d << 15;
      cnt <= 4'd15;
      q   <= '0;
    end else if (busy) begin
      if (ge) begin
        rem <= rem - dsh;
      end
      q   <= {q[14:0], ge};
      dsh <= dsh >> 1;
      cnt <= cnt - 4'd1;
    end
  end

endmodule

>>> rtl/gru_cell_ffn_readout_step.sv
// Top level of the GRU cell with ReLU/direct readout and softsign output.
// Uses gcfr_pkg, gcfr_wmem, gcfr_smem, gcfr_mac and gcfr_div.
//
//   channel  direction  tdata                      tuser
//   s_*      in         command operands           cmd
//   m_*      out        y_out                      -
//
// Every weight of a sample passes through the single MAC, one term a cycle;
// each row adds pipeline drain and post-processing, and the softsign divider
// ends the readout. Reset clears the hidden state; the weight store holds
// nothing until written. A waiting result blocks only the end of the next
// sample.
module gru_cell_ffn_readout_step #(
  parameter int HIDDEN_SIZE  = 24,
  parameter int FFN_SIZE     = 32,
  parameter int WEIGHT_DEPTH = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // weight_addr[11:0], weight_value[27:12], sample[43:28]
  input  logic [1:0]  s_tuser,   // cmd[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // y_out[15:0]
);

  localparam int H      = HIDDEN_SIZE;
  localparam int F      = FFN_SIZE;
  localparam int COLS   = H + 1;
  localparam int AW     = $clog2(WEIGHT_DEPTH);
  localparam int SD     = 4 * H + F;
  localparam int SAW    = $clog2(SD);
  localparam int HVW    = $clog2(2 * H);
  localparam int B_Z    = 2 * H;
  localparam int B_RH   = 3 * H;
  localparam int B_AF   = 4 * H;
  localparam int RO_LEN = F + 1 + H;
  localparam int JW     = $clog2(RO_LEN + 1);
  localparam int IW     = $clog2(((H > F) ? H : F) + 1);

  localparam int A_WZ = 0;
  localparam int A_BZ = A_WZ + H * COLS;
  localparam int A_WR = A_BZ + H;
  localparam int A_BR = A_WR + H * COLS;
  localparam int A_WH = A_BR + H;
  localparam int A_BH = A_WH + H * COLS;
  localparam int A_W1 = A_BH + H;
  localparam int A_B1 = A_W1 + F * COLS;
  localparam int A_WF = A_B1 + F;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ISSUE = 3'd1;
  localparam logic [2:0] S_WAIT  = 3'd2;
  localparam logic [2:0] S_POST  = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  localparam logic [2:0] K_Z  = 3'd0;
  localparam logic [2:0] K_R  = 3'd1;
  localparam logic [2:0] K_RH = 3'd2;
  localparam logic [2:0] K_C  = 3'd3;
  localparam logic [2:0] K_HN = 3'd4;
  localparam logic [2:0] K_F  = 3'd5;
  localparam logic [2:0] K_RO = 3'd6;

  localparam logic [1:0] RK_Z = 2'd0;
  localparam logic [1:0] RK_R = 2'd1;
  localparam logic [1:0] RK_C = 2'd2;
  localparam logic [1:0] RK_F = 2'd3;

  localparam logic [1:0] A_W   = 2'd0;
  localparam logic [1:0] A_OMZ = 2'd1;
  localparam logic [1:0] A_RG  = 2'd2;
  localparam logic [1:0] A_C   = 2'd3;

  localparam logic [1:0] BS_ONE = 2'd0;
  localparam logic [1:0] BS_X   = 2'd1;
  localparam logic [1:0] BS_ST  = 2'd2;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (32'(p) == WEIGHT_DEPTH - 1) ? '0 : p + AW'(1);
  endfunction

  logic [1:0]  cmd;
  logic [11:0] weight_addr;
  logic signed [15:0] weight_value;
  logic signed [15:0] sample;
  assign cmd          = s_tuser[1:0];
  assign weight_addr  = s_tdata[11:0];
  assign weight_value = s_tdata[27:12];
  assign sample       = s_tdata[43:28];

  logic [2:0] st;
  logic [2:0] seg;
  logic [IW-1:0] i;
  logic [JW-1:0] j;
  logic cb;
  logic [2*H-1:0] hv;
  logic neg;
  logic signed [15:0] x, pre, rg, creg;
  logic [AW-1:0] mat_ptr [4];
  logic [AW-1:0] bias_ptr [4];
  logic [AW-1:0] ro_ptr;

  logic accept;
  assign s_tready = (st == S_IDLE);
  assign accept   = s_tvalid & s_tready;

  logic [31:0] waddr_ext;
  logic wmem_we;
  assign waddr_ext = 32'(weight_addr);
  assign wmem_we   = accept && cmd == gcfr_pkg::CMD_WRITE && waddr_ext < 32'(WEIGHT_DEPTH);

  // Term issue for the current segment.
  logic [1:0] rk;
  logic [AW-1:0] wa;
  logic [SAW-1:0] sa, sb;
  logic [1:0] asel, bsel;
  logic [JW-1:0] len;
  logic bvld;

  always_comb begin
    int cur;
    int vb;
    int sbi;
    cur  = cb ? H : 0;
    vb   = (seg == K_C) ? B_RH : cur;
    sbi  = 0;
    rk   = RK_Z;
    asel = A_W;
    bsel = BS_ONE;
    len  = JW'(H + 2);
    unique case (seg)
      K_Z:  rk = RK_Z;
      K_R:  rk = RK_R;
      K_C:  rk = RK_C;
      K_F:  rk = RK_F;
      default: rk = RK_Z;
    endcase
    wa = mat_ptr[rk];
    sa = SAW'(B_Z + int'(i));
    unique case (seg)
      K_Z, K_R, K_C, K_F: begin
        if (j == '0) begin
          wa = bias_ptr[rk];
        end else if (j == JW'(1)) begin
          bsel = BS_X;
        end else begin
          bsel = BS_ST;
          sbi  = vb + int'(j) - 2;
        end
      end
      K_RH: begin
        len  = JW'(1);
        asel = A_RG;
        bsel = BS_ST;
        sbi  = cur + int'(i);
      end
      K_HN: begin
        len  = JW'(2);
        bsel = BS_ST;
        if (j == '0) begin
          asel = A_OMZ;
          sbi  = cur + int'(i);
        end else begin
          asel = A_C;
          sbi  = B_Z + int'(i);
        end
      end
      K_RO: begin
        len = JW'(RO_LEN);
        wa  = ro_ptr;
        if (int'(j) < F) begin
          bsel = BS_ST;
          sbi  = B_AF + int'(j);
        end else if (int'(j) > F) begin
          bsel = BS_ST;
          sbi  = cur + int'(j) - F - 1;
        end
      end
      default: len = JW'(1);
    endcase
    sb   = SAW'(sbi);
    bvld = (sbi < 2 * H) ? hv[sb[HVW-1:0]] : 1'b1;
  end

  // Post-processing write into the state memory.
  logic sw_en;
  logic [SAW-1:0] sw_addr;
  logic signed [15:0] sw_data;

  always_comb begin
    int cur;
    int oth;
    cur     = cb ? H : 0;
    oth     = cb ? 0 : H;
    sw_en   = 1'b0;
    sw_addr = SAW'(B_Z + int'(i));
    sw_data = pre;
    if (st == S_POST) begin
      unique case (seg)
        K_Z: begin
          sw_en   = 1'b1;
          sw_data = gcfr_pkg::sigm(signed'({pre[15], pre}));
        end
        K_RH: begin
          sw_en   = 1'b1;
          sw_addr = SAW'(B_RH + int'(i));
        end
        K_HN: begin
          sw_en   = 1'b1;
          sw_addr = SAW'(oth + int'(i));
        end
        K_F: begin
          sw_en   = 1'b1;
          sw_addr = SAW'(B_AF + int'(i));
          sw_data = pre[15] ? 16'sd0 : pre;
        end
        default: sw_addr = SAW'(cur);
      endcase
    end
  end

  logic signed [15:0] wq, sqa, sqb;

  gcfr_wmem #(.DEPTH(WEIGHT_DEPTH), .AW(AW)) u_wmem (
    .clk   (clk),
    .we    (wmem_we),
    .waddr (waddr_ext[AW-1:0]),
    .wdata (weight_value),
    .raddr (wa),
    .rdata (wq)
  );

  gcfr_smem #(.DEPTH(SD), .AW(SAW)) u_smem (
    .clk     (clk),
    .we      (sw_en),
    .waddr   (sw_addr),
    .wdata   (sw_data),
    .raddr_a (sa),
    .raddr_b (sb),
    .rdata_a (sqa),
    .rdata_b (sqb)
  );

  // Operand stage, aligned with the memory read data.
  gcfr_pkg::mac_ctl_t p1;
  logic [1:0] p1_asel, p1_bsel;
  logic p1_bvld;
  logic signed [15:0] opa, opb;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1 <= '0;
    end else begin
      p1.valid <= (st == S_ISSUE);
      p1.first <= (j == '0);
      p1.last  <= (j == len - JW'(1));
    end
    p1_asel <= asel;
    p1_bsel <= bsel;
    p1_bvld <= bvld;
  end

  always_comb begin
    unique case (p1_asel)
      A_W:   opa = wq;
      A_OMZ: opa = gcfr_pkg::Q_ONE - sqa;
      A_RG:  opa = rg;
      A_C:   opa = creg;
      default: opa = wq;
    endcase
    unique case (p1_bsel)
      BS_ONE: opb = gcfr_pkg::Q_ONE;
      BS_X:   opb = x;
      BS_ST:  opb = p1_bvld ? sqb : 16'sd0;
      default: opb = gcfr_pkg::Q_ONE;
    endcase
  end

  logic mac_done;
  logic signed [gcfr_pkg::ACC_W-1:0] acc;

  gcfr_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctl  (p1),
    .a    (opa),
    .b    (opb),
    .done (mac_done),
    .acc  (acc)
  );

  logic div_start, div_done;
  logic [gcfr_pkg::ACC_W-1:0] mag;
  logic [15:0] q;
  assign div_start = (st == S_WAIT) && mac_done && seg == K_RO;
  assign mag = acc[gcfr_pkg::ACC_W-1] ? gcfr_pkg::ACC_W'(-acc) : gcfr_pkg::ACC_W'(acc);

  gcfr_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .mag   (mag),
    .done  (div_done),
    .q     (q)
  );

  logic [15:0] y;
  always_comb begin
    if (neg) begin
      y = 16'(-{1'b0, q});
    end else begin
      y = (q > 16'd32767) ? 16'h7fff : q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= S_IDLE;
      hv       <= '0;
      cb       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && st != S_OUT) begin
        m_tvalid <= 1'b0;
      end
      unique case (st)
        S_IDLE: begin
          if (accept && cmd == gcfr_pkg::CMD_STEP) begin
            x   <= sample;
            seg <= K_Z;
            i   <= '0;
            j   <= '0;
            mat_ptr[RK_Z]  <= AW'(A_WZ % WEIGHT_DEPTH);
            mat_ptr[RK_R]  <= AW'(A_WR % WEIGHT_DEPTH);
            mat_ptr[RK_C]  <= AW'(A_WH % WEIGHT_DEPTH);
            mat_ptr[RK_F]  <= AW'(A_W1 % WEIGHT_DEPTH);
            bias_ptr[RK_Z] <= AW'(A_BZ % WEIGHT_DEPTH);
            bias_ptr[RK_R] <= AW'(A_BR % WEIGHT_DEPTH);
            bias_ptr[RK_C] <= AW'(A_BH % WEIGHT_DEPTH);
            bias_ptr[RK_F] <= AW'(A_B1 % WEIGHT_DEPTH);
            ro_ptr         <= AW'(A_WF % WEIGHT_DEPTH);
            st  <= S_ISSUE;
          end else if (accept && cmd == gcfr_pkg::CMD_CLEAR) begin
            hv <= '0;
          end
        end
        S_ISSUE: begin
          if (seg == K_RO) begin
            ro_ptr <= ptr_inc(ro_ptr);
          end else if (seg == K_Z || seg == K_R || seg == K_C || seg == K_F) begin
            if (j == '0) begin
              bias_ptr[rk] <= ptr_inc(bias_ptr[rk]);
            end else begin
              mat_ptr[rk] <= ptr_inc(mat_ptr[rk]);
            end
          end
          if (j == len - JW'(1)) begin
            j  <= '0;
            st <= S_WAIT;
          end else begin
            j <= j + JW'(1);
          end
        end
        S_WAIT: begin
          if (mac_done) begin
            if (seg == K_RO) begin
              neg <= acc[gcfr_pkg::ACC_W-1];
              st  <= S_DIV;
            end else begin
              pre <= gcfr_pkg::round_sat(acc);
              st  <= S_POST;
            end
          end
        end
        S_POST: begin
          st <= S_ISSUE;
          unique case (seg)
            K_Z: seg <= K_R;
            K_R: begin
              rg  <= gcfr_pkg::sigm(signed'({pre[15], pre}));
              seg <= K_RH;
            end
            K_RH: begin
              if (int'(i) == H - 1) begin
                i   <= '0;
                seg <= K_C;
              end else begin
                i   <= i + IW'(1);
                seg <= K_Z;
              end
            end
            K_C: begin
              creg <= gcfr_pkg::tanh_q(pre);
              seg  <= K_HN;
            end
            K_HN: begin
              hv[sw_addr[HVW-1:0]] <= 1'b1;
              if (int'(i) == H - 1) begin
                i   <= '0;
                cb  <= ~cb;
                seg <= K_F;
              end else begin
                i   <= i + IW'(1);
                seg <= K_C;
              end
            end
            K_F: begin
              if (int'(i) == F - 1) begin
                i   <= '0;
                seg <= K_RO;
              end else begin
                i <= i + IW'(1);
              end
            end
            default: st <= S_IDLE;
          endcase
        end
        S_DIV: begin
          if (div_done) begin
            st <= S_OUT;
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= y;
            st       <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

endmodule

>>> verif/testbench.sv
// Self-checking testbench for gru_cell_ffn_readout_step: weight writes, hidden-state
// clears and samples are streamed in, and every readout is checked against a given
// value or a local fixed-point GRU model. Depends on gcfr_pkg and the RTL top level.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int HID = 24;
  localparam int FFN = 32;
  localparam int COLS = HID + 1;
  localparam int A_BZ = HID * COLS;
  localparam int A_WR = A_BZ + HID;
  localparam int A_BR = A_WR + HID * COLS;
  localparam int A_WH = A_BR + HID;
  localparam int A_BH = A_WH + HID * COLS;
  localparam int A_W1 = A_BH + HID;
  localparam int A_B1 = A_W1 + FFN * COLS;
  localparam int A_WF = A_B1 + FFN;
  localparam int A_BF = A_WF + FFN;
  localparam int A_WRD = A_BF + 1;
  localparam int LAYOUT_END = A_WRD + HID;

  typedef struct {
    logic [1:0]  cmd;
    logic [11:0] addr;
    logic [15:0] wval;
    logic [15:0] smp;
    bit          typed;
    logic [15:0] y_typed;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;

  logic [15:0] weights [4096];
  int          hid_st [HID];
  int          rh_st [HID];
  int          hn_st [HID];
  logic [15:0] y_expected [$];
  int          errs = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  stim_row_t   directed [$];

  gru_cell_ffn_readout_step u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #40ms;
    $display("gru_cell_ffn_readout_step verification failed");
    $finish;
  end

  function automatic int wt(int a);
    return int'($signed(weights[a % 4096]));
  endfunction

  function automatic int rnd_sat(longint a);
    longint s;
    s = (a + 2048) >>> 12;
    if (s > 32767) return 32767;
    if (s < -32768) return -32768;
    return int'(s);
  endfunction

  function automatic int sig_q(int v);
    int a;
    int y;
    a = v < 0 ? -v : v;
    if (a >= 20480) y = 4096;
    else if (a >= 9728) y = (a >>> 5) + 3456;
    else if (a >= 4096) y = (a >>> 3) + 2560;
    else y = (a >>> 2) + 2048;
    return v < 0 ? 4096 - y : y;
  endfunction

  // src selects the vector in the hidden columns: 0 old state, 1 r*h, 2 new state.
  function automatic int row_pre(int wb, int ba, int x, int src);
    longint acc;
    int vk;
    acc = longint'(wt(ba)) * 4096 + longint'(wt(wb)) * x;
    for (int k = 0; k < HID; k++) begin
      vk = src == 0 ? hid_st[k] : (src == 1 ? rh_st[k] : hn_st[k]);
      acc += longint'(wt(wb + 1 + k)) * vk;
    end
    return rnd_sat(acc);
  endfunction

  function automatic logic [15:0] cell_step(int x);
    int zg [HID];
    int rg;
    int cand;
    int a;
    longint acc;
    longint mag;
    longint d;
    longint q;
    for (int i = 0; i < HID; i++) begin
      zg[i] = sig_q(row_pre(i * COLS, A_BZ + i, x, 0));
      rg = sig_q(row_pre(A_WR + i * COLS, A_BR + i, x, 0));
      rh_st[i] = rnd_sat(longint'(rg) * hid_st[i]);
    end
    for (int i = 0; i < HID; i++) begin
      cand = 2 * sig_q(2 * row_pre(A_WH + i * COLS, A_BH + i, x, 1)) - 4096;
      hn_st[i] = rnd_sat(longint'(4096 - zg[i]) * hid_st[i] + longint'(zg[i]) * cand);
    end
    for (int i = 0; i < HID; i++) hid_st[i] = hn_st[i];
    acc = longint'(wt(A_BF)) * 4096;
    for (int k = 0; k < FFN; k++) begin
      a = row_pre(A_W1 + k * COLS, A_B1 + k, x, 2);
      if (a < 0) a = 0;
      acc += longint'(a) * wt(A_WF + k);
    end
    for (int i = 0; i < HID; i++) acc += longint'(hn_st[i]) * wt(A_WRD + i);
    mag = acc < 0 ? -acc : acc;
    d = (longint'(1) << 24) + mag;
    q = (mag * 32768 + d / 2) / d;
    if (acc < 0) q = -q;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  task automatic send_cmd(logic [1:0] c, logic [11:0] a, logic [15:0] w, logic [15:0] smp,
                          bit typed = 1'b0, logic [15:0] y_typed = '0);
    bit taken;
    logic [15:0] y;
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= c;
    s_tdata <= {4'b0, smp, w, a};
    do begin
      @(negedge clk);
      taken = s_tready;
      @(posedge clk);
    end while (!taken);
    case (c)
      gcfr_pkg::CMD_WRITE: weights[a] = w;
      gcfr_pkg::CMD_CLEAR: for (int i = 0; i < HID; i++) hid_st[i] = 0;
      gcfr_pkg::CMD_STEP: begin
        y = cell_step(int'($signed(smp)));
        y_expected = {y_expected, typed ? y_typed : y};
      end
      default: ;
    endcase
  endtask

  task automatic fill_layout(int span);
    for (int a = 0; a < LAYOUT_END; a++) begin
      send_cmd(gcfr_pkg::CMD_WRITE, a[11:0],
               span == 0 ? 16'h0 : 16'($urandom_range(2 * span) - span), 16'h0);
    end
  endtask

  always @(posedge clk) begin
    m_tready <= rst ? 1'b0 : ($urandom_range(99) >= stall_pct);
  end

  always @(negedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (y_expected.size() == 0) begin
        $display("%0t: unexpected transaction y_out=%h", $time, m_tdata);
        errs++;
      end else begin
        if (m_tdata !== y_expected[0]) begin
          $display("%0t: y_out mismatch expected=%h actual=%h", $time, y_expected[0], m_tdata);
          errs++;
        end
        void'(y_expected.pop_front());
      end
    end
  end

  initial begin
    logic [1:0] c;
    logic [15:0] smp;
    logic [11:0] a;
    logic [15:0] w;
    int pick;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 1'b0;
    for (int i = 0; i < HID; i++) hid_st[i] = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed = '{
      '{gcfr_pkg::CMD_STEP,  12'd0,     16'h0000, 16'h0000, 1'b1, 16'h0000},
      '{gcfr_pkg::CMD_STEP,  12'd0,     16'h0000, 16'h7fff, 1'b1, 16'h0000},
      '{gcfr_pkg::CMD_STEP,  12'd0,     16'h0000, 16'h8000, 1'b1, 16'h0000},
      '{CMD_UNUSED,          12'hfff,   16'hffff, 16'hffff, 1'b0, 16'h0000},
      '{gcfr_pkg::CMD_WRITE, 12'(A_BF), 16'h7fff, 16'h0000, 1'b0, 16'h0000},
      '{gcfr_pkg::CMD_STEP,  12'd0,     16'h0000, 16'h0000, 1'b0, 16'h0000},
      '{gcfr_pkg::CMD_WRITE, 12'(A_BF), 16'h8000, 16'h0000, 1'b0, 16'h0000},
      '{gcfr_pkg::CMD_STEP,  12'd0,     16'h0000, 16'h0000, 1'b0, 16'h0000},
      '{gcfr_pkg::CMD_WRITE, 12'hfff,   16'h5555, 16'h0000, 1'b0, 16'h0000},
      '{gcfr_pkg::CMD_WRITE, 12'hfff,   16'haaaa, 16'h0000, 1'b0, 16'h0000},
      '{gcfr_pkg::CMD_WRITE, 12'd0,     16'h7fff, 16'h0000, 1'b0, 16'h0000},
      '{gcfr_pkg::CMD_WRITE, 12'(A_BZ), 16'h8000, 16'h0000, 1'b0, 16'h0000},
      '{gcfr_pkg::CMD_WRITE, 12'(A_WRD), 16'h7fff, 16'h0000, 1'b0, 16'h0000},
      '{gcfr_pkg::CMD_STEP,  12'd0,     16'h0000, 16'h7fff, 1'b0, 16'h0000},
      '{gcfr_pkg::CMD_STEP,  12'd0,     16'h0000, 16'h8000, 1'b0, 16'h0000},
      '{gcfr_pkg::CMD_CLEAR, 12'd0,     16'h0000, 16'h0000, 1'b0, 16'h0000},
      '{gcfr_pkg::CMD_STEP,  12'd0,     16'h0000, 16'h1000, 1'b0, 16'h0000}
    };

    fill_layout(0);
    foreach (directed[i]) begin
      send_cmd(directed[i].cmd, directed[i].addr, directed[i].wval, directed[i].smp,
               directed[i].typed, directed[i].y_typed);
    end
    fill_layout(600);

    for (int i = 0; i < 200; i++) begin
      case (i / 50)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 64; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 64; end
        default: begin idle_pct = 28; stall_pct = 28; end
      endcase
      if (i == 120) begin
        s_tvalid <= 1'b0;
        wait (y_expected.size() == 0);
        @(posedge clk);
      end
      pick = $urandom_range(99);
      a = 12'($urandom_range(LAYOUT_END - 1));
      w = 16'($urandom_range(1200) - 600);
      smp = 16'($urandom_range(16384) - 8192);
      if (pick < 55) begin
        c = gcfr_pkg::CMD_STEP;
        if ($urandom_range(3) == 0) smp = 16'($urandom);
      end else if (pick < 85) begin
        c = gcfr_pkg::CMD_WRITE;
        if ($urandom_range(4) == 0) w = 16'($urandom);
        if ($urandom_range(4) == 0) a = 12'($urandom);
      end else if (pick < 95) begin
        c = gcfr_pkg::CMD_CLEAR;
      end else begin
        c = CMD_UNUSED;
        a = 12'($urandom);
        w = 16'($urandom);
        smp = 16'($urandom);
      end
      send_cmd(c, a, w, smp);
    end

    s_tvalid <= 1'b0;
    wait (y_expected.size() == 0);
    repeat (100) @(posedge clk);
    if (errs == 0 && y_expected.size() == 0) begin
      $display("gru_cell_ffn_readout_step verification clean");
    end else begin
      $display("gru_cell_ffn_readout_step verification failed");
    end
    $finish;
  end

endmodule
